/* sv/tirs_pkg.sv */
package tirs_pkg;

  // Limits and fixed figures of the scan
  localparam int unsigned VERTEX_CAP    = 8192;
  localparam int unsigned SEARCH_WINDOW = 262144;
  localparam int unsigned RUN_FACTOR    = 12;
  localparam int unsigned MIN_VERTICES  = 3;
  localparam int unsigned TRI_CORNERS   = 3;
  localparam int unsigned INDEXED_MIN   = 6;
  localparam int unsigned PATTERN_LEN   = 6;

  // Field widths
  localparam int unsigned VC_W     = 14;
  localparam int unsigned SL_W     = 19;
  localparam int unsigned POS_W    = 18;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned DEG_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 19;

  // Start pattern of an index run, oldest byte first
  localparam logic [7:0] PATTERN [PATTERN_LEN] =
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH = 1'b1;

  // Result kinds
  localparam logic KIND_INDEX   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  index_value;
    logic              found;
    logic [POS_W-1:0]  pattern_offset;
    logic [CNT_W-1:0]  index_count;
    logic [DEG_W-1:0]  degenerate_count;
    logic              indexed;
  } result_t;

  // Up to two results written to the queue in one cycle, first one first
  typedef struct packed {
    logic    first;
    logic    second;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

/* sv/tirs_if.sv */
interface tirs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tirs_result_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [tirs_pkg::IDX_W-1:0]   index_value;
  logic                         found;
  logic [tirs_pkg::POS_W-1:0]   pattern_offset;
  logic [tirs_pkg::CNT_W-1:0]   index_count;
  logic [tirs_pkg::DEG_W-1:0]   degenerate_count;
  logic                         indexed;
  modport source (output valid, kind, index_value, found, pattern_offset, index_count,
                  degenerate_count, indexed, input ready);
  modport sink   (input valid, kind, index_value, found, pattern_offset, index_count,
                  degenerate_count, indexed, output ready);
endinterface

interface tirs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tirs_pkg::CFG_IDX_W-1:0]    index;
  logic [tirs_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tirs_core.sv */
module tirs_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  logic [tirs_pkg::VC_W-1:0]     vertex_count,
  input  logic [tirs_pkg::SL_W-1:0]     search_length,
  output tirs_pkg::push_t               push
);

  typedef enum logic [1:0] {PH_SEARCH, PH_RUN, PH_DRAIN} phase_t;

  localparam int unsigned WIN_N = tirs_pkg::PATTERN_LEN - 1;

  phase_t                        phase, phase_next;
  logic [tirs_pkg::POS_W-1:0]    pos, pos_next;
  logic [7:0]                    win [WIN_N];
  logic [7:0]                    win_next [WIN_N];
  logic                          fill, fill_next;
  logic [tirs_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [1:0]                    mod3, mod3_next;
  logic [tirs_pkg::DEG_W-1:0]    deg, deg_next;
  logic [tirs_pkg::POS_W-1:0]    off, off_next;
  logic [tirs_pkg::IDX_W-1:0]    prev [2];

  logic [tirs_pkg::VC_W-1:0]     vc_eff;
  logic [tirs_pkg::SL_W-1:0]     sl_eff;
  logic [tirs_pkg::CNT_W-1:0]    limit;
  logic                          few;
  logic                          match;
  logic [tirs_pkg::SL_W-1:0]     pos_ext;
  logic [tirs_pkg::WORD_W-1:0]   word;
  logic [tirs_pkg::IDX_W-1:0]    word_idx;
  logic                          too_big;
  logic                          accept_go;
  logic [tirs_pkg::CNT_W-1:0]    cnt_base, cnt_inc;
  logic [1:0]                    mod_base;
  logic [tirs_pkg::DEG_W-1:0]    deg_base;
  logic                          degen;
  logic                          prev_wr;
  logic                          e_idx, e_sum, e_last, sum_found;
  tirs_pkg::result_t             idx_rec, sum_rec;

  // Clamp the registers to the supported range
  assign vc_eff = (vertex_count > tirs_pkg::VC_W'(tirs_pkg::VERTEX_CAP))
                  ? tirs_pkg::VC_W'(tirs_pkg::VERTEX_CAP) : vertex_count;
  assign sl_eff = (search_length > tirs_pkg::SL_W'(tirs_pkg::SEARCH_WINDOW))
                  ? tirs_pkg::SL_W'(tirs_pkg::SEARCH_WINDOW) : search_length;
  assign limit  = tirs_pkg::CNT_W'(vc_eff) * tirs_pkg::CNT_W'(tirs_pkg::RUN_FACTOR);
  assign few    = vc_eff < tirs_pkg::VC_W'(tirs_pkg::MIN_VERTICES);
  assign pos_ext = {1'b0, pos};

  // Pattern sits in the five held bytes plus the incoming one
  assign match = (pos >= tirs_pkg::POS_W'(WIN_N)) && (pos_ext < sl_eff)
              && (win[0] == tirs_pkg::PATTERN[0]) && (win[1] == tirs_pkg::PATTERN[1])
              && (win[2] == tirs_pkg::PATTERN[2]) && (win[3] == tirs_pkg::PATTERN[3])
              && (win[4] == tirs_pkg::PATTERN[4]) && (data_byte == tirs_pkg::PATTERN[5]);

  // Word four bytes old once the new byte is in
  assign word     = {win[0], win[1]};
  assign word_idx = word[tirs_pkg::IDX_W-1:0];
  assign too_big  = word >= tirs_pkg::WORD_W'(vc_eff);
  assign cnt_inc  = cnt_base + tirs_pkg::CNT_W'(1);
  assign degen    = (mod_base == 2'(tirs_pkg::TRI_CORNERS - 1))
                 && ((prev[0] == prev[1]) || (prev[1] == word_idx) || (prev[0] == word_idx));

  // Advance the scan by one byte
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    fill_next  = fill;
    off_next   = off;
    for (int i = 0; i < WIN_N; i++) win_next[i] = win[i];
    cnt_base   = cnt;
    mod_base   = mod3;
    deg_base   = deg;
    accept_go  = 1'b0;
    e_sum      = 1'b0;
    sum_found  = 1'b0;
    unique case (phase)
      PH_SEARCH: begin
        if (few) begin
          e_sum      = 1'b1;
          phase_next = PH_DRAIN;
        end else begin
          for (int i = 0; i < WIN_N - 1; i++) win_next[i] = win[i+1];
          win_next[WIN_N-1] = data_byte;
          pos_next = pos + tirs_pkg::POS_W'(1);
          if (match) begin
            phase_next = PH_RUN;
            off_next   = pos - tirs_pkg::POS_W'(WIN_N);
            cnt_base   = '0;
            mod_base   = '0;
            deg_base   = '0;
            fill_next  = 1'b0;
            accept_go  = 1'b1;
          end else if (pos_ext + tirs_pkg::SL_W'(1) >= sl_eff) begin
            e_sum      = 1'b1;
            phase_next = PH_DRAIN;
          end
        end
      end
      PH_RUN: begin
        for (int i = 0; i < WIN_N - 1; i++) win_next[i] = win[i+1];
        win_next[WIN_N-1] = data_byte;
        fill_next = ~fill;
        accept_go = fill;
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    cnt_next  = cnt_base;
    mod3_next = mod_base;
    deg_next  = deg_base;
    e_idx     = 1'b0;
    prev_wr   = 1'b0;
    if (accept_go) begin
      if (too_big) begin
        e_sum      = 1'b1;
        sum_found  = 1'b1;
        phase_next = PH_DRAIN;
      end else begin
        e_idx     = 1'b1;
        prev_wr   = 1'b1;
        cnt_next  = cnt_inc;
        mod3_next = (mod_base == 2'(tirs_pkg::TRI_CORNERS - 1))
                    ? 2'd0 : mod_base + 2'd1;
        deg_next  = deg_base + tirs_pkg::DEG_W'(degen);
        if (cnt_inc >= limit) begin
          e_sum      = 1'b1;
          sum_found  = 1'b1;
          phase_next = PH_DRAIN;
        end
      end
    end

    // A run still open at end of stream closes with its summary
    e_last = last_byte && (phase_next == PH_RUN);
    if (e_last) sum_found = 1'b1;
  end

  // Build the two result records
  always_comb begin
    idx_rec             = '0;
    idx_rec.kind        = tirs_pkg::KIND_INDEX;
    idx_rec.index_value = word_idx;
    sum_rec             = '0;
    sum_rec.kind        = tirs_pkg::KIND_SUMMARY;
    if (sum_found) begin
      sum_rec.found            = 1'b1;
      sum_rec.pattern_offset   = off_next;
      sum_rec.index_count      = cnt_next;
      sum_rec.degenerate_count = deg_next;
      sum_rec.indexed          = cnt_next >= tirs_pkg::CNT_W'(tirs_pkg::INDEXED_MIN);
    end
  end

  assign push.first  = step && (e_idx || e_sum || e_last);
  assign push.second = step && e_idx && (e_sum || e_last);
  assign push.r0     = e_idx ? idx_rec : sum_rec;
  assign push.r1     = sum_rec;

  // Hold scan state; the last byte rearms everything
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      pos   <= '0;
      for (int i = 0; i < WIN_N; i++) win[i] <= '0;
      fill  <= 1'b0;
      cnt   <= '0;
      mod3  <= '0;
      deg   <= '0;
      off   <= '0;
    end else if (step) begin
      if (last_byte) begin
        phase <= PH_SEARCH;
        pos   <= '0;
        for (int i = 0; i < WIN_N; i++) win[i] <= '0;
        fill  <= 1'b0;
        cnt   <= '0;
        mod3  <= '0;
        deg   <= '0;
        off   <= '0;
      end else begin
        phase <= phase_next;
        pos   <= pos_next;
        for (int i = 0; i < WIN_N; i++) win[i] <= win_next[i];
        fill  <= fill_next;
        cnt   <= cnt_next;
        mod3  <= mod3_next;
        deg   <= deg_next;
        off   <= off_next;
      end
    end
  end

  // Keep the last two corners of the open triangle
  always_ff @(posedge clk) begin
    if (step && prev_wr) begin
      prev[0] <= prev[1];
      prev[1] <= word_idx;
    end
  end

endmodule

/* sv/tirs_outq.sv */
module tirs_outq (
  input  logic               clk,
  input  logic               rst,
  input  tirs_pkg::push_t    push,
  output logic               room,
  output logic               valid,
  input  logic               ready,
  output tirs_pkg::result_t  head
);

  localparam int unsigned DEPTH = 4;

  tirs_pkg::result_t mem [DEPTH];
  logic [1:0]        wr_ptr, rd_ptr;
  logic [2:0]        count, count_next;
  logic              pop;

  assign valid = count != 3'd0;
  assign head  = mem[rd_ptr];
  assign pop   = valid && ready;
  // Space for the two results one byte can cause
  assign room  = count <= 3'(DEPTH - 2);

  assign count_next = count + 3'(push.first) + 3'(push.second) - 3'(pop);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + 2'(push.first) + 2'(push.second);
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count_next;
    end
  end

  // Store results in arrival order
  always_ff @(posedge clk) begin
    if (push.first) mem[wr_ptr] <= push.r0;
    if (push.second) mem[wr_ptr + 2'd1] <= push.r1;
  end

endmodule

/* sv/triangle_index_run_scanner.sv */
// Channel | Dir | Payload                                          | Request
// src     | in  | data_byte, last_byte                             | one stream byte
// res     | out | kind, index_value, found, pattern_offset,        | one result
//         |     | index_count, degenerate_count, indexed           |
// cfg     | in  | index (0 vertex_count, 1 search_length), data    | one register write
//
// One byte is taken per cycle while the queue has room; the scan is combinational from
// the input register into a four-entry result queue, so throughput is one byte per cycle
// while results drain. A byte that yields an index and a summary fills two queue entries;
// intake pauses when fewer than two entries are free. A byte passes through the input
// register and the queue before its first result is offered. Synchronous reset clears the
// scan state and the queue; registers return to 8192 and 262144. cfg is always ready.
module triangle_index_run_scanner (
  input logic           clk,
  input logic           rst,
  tirs_byte_if.sink     src,
  tirs_result_if.source res,
  tirs_cfg_if.sink      cfg
);

  logic                          in_valid;
  logic [7:0]                    in_byte;
  logic                          in_last;
  logic                          room;
  logic                          step;
  logic [tirs_pkg::VC_W-1:0]     vertex_count;
  logic [tirs_pkg::SL_W-1:0]     search_length;
  tirs_pkg::push_t               push;
  tirs_pkg::result_t             head;

  assign step      = in_valid && room;
  assign src.ready = !in_valid || step;
  assign cfg.ready = 1'b1;

  // Hold the input request until the queue has space
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (src.ready) begin
      in_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      in_byte <= src.data_byte;
      in_last <= src.last_byte;
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= tirs_pkg::VC_W'(tirs_pkg::VERTEX_CAP);
      search_length <= tirs_pkg::SL_W'(tirs_pkg::SEARCH_WINDOW);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tirs_pkg::REG_VERTEX_COUNT:  vertex_count  <= cfg.data[tirs_pkg::VC_W-1:0];
        tirs_pkg::REG_SEARCH_LENGTH: search_length <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  tirs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .last_byte     (in_last),
    .vertex_count  (vertex_count),
    .search_length (search_length),
    .push          (push)
  );

  tirs_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (res.valid),
    .ready (res.ready),
    .head  (head)
  );

  assign res.kind             = head.kind;
  assign res.index_value      = head.index_value;
  assign res.found            = head.found;
  assign res.pattern_offset   = head.pattern_offset;
  assign res.index_count      = head.index_count;
  assign res.degenerate_count = head.degenerate_count;
  assign res.indexed          = head.indexed;

  // Two results from one byte always come as a pair
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first && push.r0.kind == tirs_pkg::KIND_INDEX
                   && push.r1.kind == tirs_pkg::KIND_SUMMARY)
    else $error("second result without an index before it");

  // A not-found summary carries no run figures
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == tirs_pkg::KIND_SUMMARY && !res.found)
      |-> res.index_count == '0 && res.pattern_offset == '0 && res.degenerate_count == '0)
    else $error("not-found summary carries run figures");

  // The indexed flag follows the index count
  a_indexed: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == tirs_pkg::KIND_SUMMARY)
      |-> res.indexed == (res.index_count >= tirs_pkg::CNT_W'(tirs_pkg::INDEXED_MIN)))
    else $error("indexed flag disagrees with index count");

  // The queue is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result offered straight after reset");

endmodule

/* tb/tirs_result_check.sv */
module tirs_result_check (
  input  logic   clk,
  input  logic   rst,
  tirs_byte_if   src,
  tirs_result_if res,
  tirs_cfg_if    cfg,
  output int     mismatches,
  output int     outstanding,
  output int     indices_seen,
  output int     runs_seen,
  output int     found_runs
);

  typedef enum logic [1:0] {SCAN_SEARCH, SCAN_RUN, SCAN_DRAIN} scan_phase_t;

  // Register copies, written as the block sees them
  logic [tirs_pkg::VC_W-1:0] vertex_count;
  logic [tirs_pkg::SL_W-1:0] search_length;

  // Scan state
  logic [7:0]                 window [tirs_pkg::PATTERN_LEN];
  int unsigned                position;
  scan_phase_t                phase;
  logic                       odd_byte;
  logic [tirs_pkg::IDX_W-1:0] corner_a;
  logic [tirs_pkg::IDX_W-1:0] corner_b;
  int unsigned                run_indices;
  int unsigned                degenerate_tris;
  int unsigned                match_at;

  // Results owed by the block, oldest first
  tirs_pkg::result_t expected_results [$];

  function automatic int unsigned vc_clamped();
    return (vertex_count > tirs_pkg::VERTEX_CAP) ? tirs_pkg::VERTEX_CAP : vertex_count;
  endfunction

  function automatic void clear_scan();
    foreach (window[i]) window[i] = 8'h00;
    position        = 0;
    phase           = SCAN_SEARCH;
    odd_byte        = 1'b0;
    corner_a        = '0;
    corner_b        = '0;
    run_indices     = 0;
    degenerate_tris = 0;
    match_at        = 0;
  endfunction

  function automatic void shift_window(input logic [7:0] b);
    for (int i = 0; i < tirs_pkg::PATTERN_LEN - 1; i++) window[i] = window[i + 1];
    window[tirs_pkg::PATTERN_LEN - 1] = b;
  endfunction

  // A not-found summary carries nothing but its kind
  function automatic void post_summary(input logic hit);
    tirs_pkg::result_t r;
    r = '0;
    r.kind = tirs_pkg::KIND_SUMMARY;
    if (hit) begin
      r.found            = 1'b1;
      r.pattern_offset   = match_at[tirs_pkg::POS_W-1:0];
      r.index_count      = run_indices[tirs_pkg::CNT_W-1:0];
      r.degenerate_count = degenerate_tris[tirs_pkg::DEG_W-1:0];
      r.indexed          = (run_indices >= tirs_pkg::INDEXED_MIN);
    end
    expected_results = {expected_results, r};
  endfunction

  // Commit one word: end the run on an oversized index or at the run limit
  function automatic void take_word(input logic [tirs_pkg::WORD_W-1:0] word);
    tirs_pkg::result_t r;
    int unsigned       n;
    if (word >= vc_clamped()) begin
      post_summary(1'b1);
      phase = SCAN_DRAIN;
      return;
    end
    r = '0;
    r.kind        = tirs_pkg::KIND_INDEX;
    r.index_value = word[tirs_pkg::IDX_W-1:0];
    expected_results = {expected_results, r};
    n = run_indices + 1;
    if (n % tirs_pkg::TRI_CORNERS == 0 &&
        (corner_a == corner_b || corner_b == word[tirs_pkg::IDX_W-1:0] ||
         corner_a == word[tirs_pkg::IDX_W-1:0]))
      degenerate_tris++;
    corner_a    = corner_b;
    corner_b    = word[tirs_pkg::IDX_W-1:0];
    run_indices = n;
    if (n >= vc_clamped() * tirs_pkg::RUN_FACTOR) begin
      post_summary(1'b1);
      phase = SCAN_DRAIN;
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic last);
    int unsigned span;
    logic        hit;
    case (phase)
      SCAN_SEARCH: begin
        if (vc_clamped() < tirs_pkg::MIN_VERTICES) begin
          post_summary(1'b0);
          phase = SCAN_DRAIN;
        end else begin
          span = (search_length > tirs_pkg::SEARCH_WINDOW) ? tirs_pkg::SEARCH_WINDOW
                                                           : search_length;
          shift_window(b);
          hit = (position >= tirs_pkg::PATTERN_LEN - 1) && (position < span);
          for (int i = 0; i < tirs_pkg::PATTERN_LEN; i++)
            if (window[i] != tirs_pkg::PATTERN[i]) hit = 1'b0;
          if (hit) begin
            match_at        = position - (tirs_pkg::PATTERN_LEN - 1);
            phase           = SCAN_RUN;
            run_indices     = 0;
            degenerate_tris = 0;
            odd_byte        = 1'b0;
            take_word({window[0], window[1]});
          end else if (position + 1 >= span) begin
            post_summary(1'b0);
            phase = SCAN_DRAIN;
          end
          if (position < tirs_pkg::SEARCH_WINDOW) position++;
        end
      end
      SCAN_RUN: begin
        // a word is four bytes old when it reaches the front of the window
        shift_window(b);
        odd_byte = !odd_byte;
        if (!odd_byte) take_word({window[0], window[1]});
      end
      default: ;
    endcase
    // close a live run on the last byte, dropping young words, and rearm
    if (last) begin
      if (phase == SCAN_RUN) post_summary(1'b1);
      clear_scan();
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Advance the prediction on every request and match each result in order
  always @(posedge clk) begin : watch
    tirs_pkg::result_t got;
    tirs_pkg::result_t want;
    if (rst) begin
      vertex_count  = tirs_pkg::VC_W'(tirs_pkg::VERTEX_CAP);
      search_length = tirs_pkg::SL_W'(tirs_pkg::SEARCH_WINDOW);
      clear_scan();
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          tirs_pkg::REG_VERTEX_COUNT:  vertex_count  = cfg.data[tirs_pkg::VC_W-1:0];
          tirs_pkg::REG_SEARCH_LENGTH: search_length = cfg.data;
        endcase
      end
      if (src.valid && src.ready) scan_byte(src.data_byte, src.last_byte);
      if (res.valid && res.ready) begin
        got.kind             = res.kind;
        got.index_value      = res.index_value;
        got.found            = res.found;
        got.pattern_offset   = res.pattern_offset;
        got.index_count      = res.index_count;
        got.degenerate_count = res.degenerate_count;
        got.indexed          = res.indexed;
        if (got.kind == tirs_pkg::KIND_INDEX) indices_seen++;
        else begin
          runs_seen++;
          if (got.found) found_runs++;
        end
        if (expected_results.size() == 0) begin
          $error("result with nothing owed: kind %0d index %0d", got.kind, got.index_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", 32'(want.kind), 32'(got.kind));
          compare_field("index_value", 32'(want.index_value), 32'(got.index_value));
          compare_field("found", 32'(want.found), 32'(got.found));
          compare_field("pattern_offset", 32'(want.pattern_offset),
                        32'(got.pattern_offset));
          compare_field("index_count", 32'(want.index_count), 32'(got.index_count));
          compare_field("degenerate_count", 32'(want.degenerate_count),
                        32'(got.degenerate_count));
          compare_field("indexed", 32'(want.indexed), 32'(got.indexed));
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;

  localparam int unsigned RANDOM_BYTES  = 720;
  localparam int unsigned PHASE_BYTES   = 90;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 2000;

  // Opening settings of the random part, then picks from the extremes
  localparam int unsigned FIXED_VC [4] = '{3, 16383, 0, 8193};
  localparam int unsigned FIXED_SL [4] = '{524287, 12, 262144, 7};
  localparam int unsigned VC_PICKS [12] = '{0, 1, 2, 3, 4, 5, 9, 100, 8191, 8192, 8193, 16383};
  localparam int unsigned SL_PICKS [13] =
    '{0, 1, 5, 6, 7, 9, 12, 16, 40, 262143, 262144, 262145, 524287};

  logic clk = 1'b0;
  logic rst = 1'b1;

  tirs_byte_if   byte_ch ();
  tirs_result_if result_ch ();
  tirs_cfg_if    cfg_ch ();

  int          mismatches;
  int          outstanding;
  int          indices_seen;
  int          runs_seen;
  int          found_runs;
  int unsigned bytes_sent = 0;
  int unsigned streams_sent = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles;
  int unsigned vc_now = tirs_pkg::VERTEX_CAP;
  logic        calm = 1'b0;
  logic [7:0]  stream_bytes [$];

  triangle_index_run_scanner dut (
    .clk (clk),
    .rst (rst),
    .src (byte_ch),
    .res (result_ch),
    .cfg (cfg_ch)
  );

  tirs_result_check result_check (
    .clk          (clk),
    .rst          (rst),
    .src          (byte_ch),
    .res          (result_ch),
    .cfg          (cfg_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .indices_seen (indices_seen),
    .runs_seen    (runs_seen),
    .found_runs   (found_runs)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filler biased towards the bytes of the start pattern
  function automatic void add_noise(input int unsigned count);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0:       stream_bytes = {stream_bytes, 8'h00};
        1:       stream_bytes = {stream_bytes, 8'($urandom_range(0, 2))};
        default: stream_bytes = {stream_bytes, 8'($urandom_range(0, 255))};
      endcase
    end
  endfunction

  // Mostly a start pattern and an index run; now and then noise or a spoilt pattern
  function automatic void build_stream();
    int unsigned mode;
    int unsigned evc;
    int unsigned words;
    int unsigned r;
    int unsigned slip;
    logic [15:0] w;
    logic [15:0] prev;
    stream_bytes.delete();
    evc  = (vc_now > tirs_pkg::VERTEX_CAP) ? tirs_pkg::VERTEX_CAP : vc_now;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      add_noise($urandom_range(1, 12));
      return;
    end
    add_noise($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
    slip = stream_bytes.size();
    for (int i = 0; i < tirs_pkg::PATTERN_LEN; i++)
      stream_bytes = {stream_bytes, tirs_pkg::PATTERN[i]};
    if (mode == 1) begin
      slip += $urandom_range(0, tirs_pkg::PATTERN_LEN - 1);
      stream_bytes[slip] = stream_bytes[slip] ^ (8'h01 << $urandom_range(0, 7));
      add_noise($urandom_range(0, 10));
      return;
    end
    // few vertices make the run limit reachable, so run long and rarely overshoot
    words = (evc <= 4) ? $urandom_range(30, 60) : $urandom_range(0, 14);
    prev  = '0;
    repeat (words) begin
      r = $urandom_range(0, 63);
      if (r < ((evc <= 4) ? 1 : 4)) w = 16'($urandom_range(evc, 65535));
      else if (r < 20)              w = prev;
      else if (r < 24)              w = 16'(evc > 0 ? evc - 1 : 0);
      else                          w = 16'($urandom_range(0, evc > 0 ? evc - 1 : 0));
      stream_bytes = {stream_bytes, w[15:8], w[7:0]};
      prev = w;
    end
    add_noise($urandom_range(0, 5));
  endfunction

  // Offer each byte after a random gap and hold the request until taken
  task automatic send_stream();
    int unsigned gap;
    calm = ($urandom_range(0, 3) == 0);
    streams_sent++;
    foreach (stream_bytes[i]) begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_ch.valid     <= 1'b1;
      byte_ch.data_byte <= stream_bytes[i];
      byte_ch.last_byte <= (i == stream_bytes.size() - 1);
      do @(posedge clk); while (!byte_ch.ready);
      bytes_sent++;
    end
  endtask

  // Drop the byte request, let every owed result drain, then allow for silent bytes
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tirs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tirs_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input int unsigned vc, input int unsigned sl);
    wait_idle();
    write_reg(tirs_pkg::REG_VERTEX_COUNT, vc[tirs_pkg::CFG_DATA_W-1:0]);
    write_reg(tirs_pkg::REG_SEARCH_LENGTH, sl[tirs_pkg::CFG_DATA_W-1:0]);
    cfg_ch.valid <= 1'b0;
    vc_now = vc;
    settings_used++;
  endtask

  // Result side: stall at random before taking each result
  initial begin : result_sink
    int unsigned stall;
    result_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // End the run if no request moves on any channel for too long
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("No request moved for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_goal;
    int unsigned phase_start;
    int unsigned k;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Largest index, a degenerate triangle, then an oversized index ends the run
    stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h1F, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hBB, 8'hCC, 8'hDD,
                     8'hEE, 8'hFF};
    send_stream();
    // Too few vertices: not-found at the first byte
    configure(2, tirs_pkg::SEARCH_WINDOW);
    stream_bytes = '{8'hFF};
    send_stream();
    // Pattern one byte past the search length
    configure(tirs_pkg::VERTEX_CAP, 5);
    stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02};
    send_stream();
    // Empty search length gives up at once
    configure(tirs_pkg::VERTEX_CAP, 0);
    stream_bytes = '{8'h00};
    send_stream();

    // Random streams in phases of one register setting each
    random_goal = bytes_sent + RANDOM_BYTES;
    k = 0;
    while (bytes_sent < random_goal) begin
      if (k < 4) configure(FIXED_VC[k], FIXED_SL[k]);
      else configure(VC_PICKS[$urandom_range(0, 11)], SL_PICKS[$urandom_range(0, 12)]);
      k++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < random_goal) begin
        build_stream();
        send_stream();
      end
    end

    wait_idle();
    $display("Sent %0d bytes in %0d streams across %0d register settings",
             bytes_sent, streams_sent, settings_used);
    $display("Checked %0d index results and %0d run summaries (%0d with the pattern found)",
             indices_seen, runs_seen, found_runs);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* triangle_index_run_scanner.f */
sv/tirs_pkg.sv
sv/tirs_if.sv
sv/tirs_core.sv
sv/tirs_outq.sv
sv/triangle_index_run_scanner.sv
tb/tirs_result_check.sv
tb/testbench.sv
